FILE: rtl/core/gait_step_phase_detector_top_assert.svh
// assertion macros for the gait step phase detector rtl
`ifndef GAIT_STEP_PHASE_DETECTOR_TOP_ASSERT_SVH
`define GAIT_STEP_PHASE_DETECTOR_TOP_ASSERT_SVH

// same-cycle implication, checked on clk, off while rst_n is low
`define GSPD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk, off while rst_n is low
`define GSPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/gspd_pkg.sv
// types and constants of the gait step phase detector
package gspd_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int COUNT_BITS     = 16;
    localparam int SIGN_BITS      = 2;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = SAMPLE_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SWING_THR = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GOOD_THR  = 2'd1;

    typedef enum logic [2:0] {
        PH_LOOK      = 3'd0,
        PH_SWING     = 3'd1,
        PH_POTENTIAL = 3'd2,
        PH_STRIKE    = 3'd3,
        PH_FLAT      = 3'd4,
        PH_HEELOFF   = 3'd5
    } phase_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] swing_threshold;
        logic signed [SAMPLE_BITS-1:0] good_threshold;
    } cfg_t;

    typedef struct packed {
        phase_t                        phase;
        logic                          beep;
        logic [COUNT_BITS-1:0]         steps_seen;
        logic [COUNT_BITS-1:0]         good_steps;
        logic signed [SAMPLE_BITS-1:0] peak_swing;
        logic signed [SAMPLE_BITS-1:0] valley_min;
    } result_t;

endpackage

FILE: rtl/core/gspd_cfg_regs.sv
// threshold configuration registers
module gspd_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [gspd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [gspd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output gspd_pkg::cfg_t                       cfg
);

    gspd_pkg::cfg_t cfg_reg;
    gspd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                gspd_pkg::REG_SWING_THR: cfg_next.swing_threshold = $signed(cfg_data);
                gspd_pkg::REG_GOOD_THR:  cfg_next.good_threshold  = $signed(cfg_data);
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/gspd_phase_fsm.sv
// gait phase machine with swing, valley and lift trackers and step counters
`include "gait_step_phase_detector_top_assert.svh"

module gspd_phase_fsm (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 step_en,
    input  logic signed [gspd_pkg::SAMPLE_BITS-1:0] sample,
    input  logic [gspd_pkg::SIGN_BITS-1:0]       peak_sign,
    input  gspd_pkg::cfg_t                       cfg,
    output gspd_pkg::result_t                    result
);

    gspd_pkg::phase_t                        phase_reg;
    gspd_pkg::phase_t                        phase_next;
    logic signed [gspd_pkg::SAMPLE_BITS-1:0] swing_max_reg;
    logic signed [gspd_pkg::SAMPLE_BITS-1:0] swing_max_next;
    logic signed [gspd_pkg::SAMPLE_BITS-1:0] heel_valley_reg;
    logic signed [gspd_pkg::SAMPLE_BITS-1:0] heel_valley_next;
    logic signed [gspd_pkg::SAMPLE_BITS-1:0] lift_min_reg;
    logic signed [gspd_pkg::SAMPLE_BITS-1:0] lift_min_next;
    logic                                    first_under_reg;
    logic                                    first_under_next;
    logic                                    armed_reg;
    logic                                    armed_next;
    logic [gspd_pkg::COUNT_BITS-1:0]         step_cnt_reg;
    logic [gspd_pkg::COUNT_BITS-1:0]         step_cnt_next;
    logic [gspd_pkg::COUNT_BITS-1:0]         good_cnt_reg;
    logic [gspd_pkg::COUNT_BITS-1:0]         good_cnt_next;
    logic                                    beep_next;

    logic sign_neg;
    logic sign_pos;
    logic sample_neg;
    logic sample_pos;

    assign sign_neg   = peak_sign[gspd_pkg::SIGN_BITS-1];
    assign sign_pos   = !peak_sign[gspd_pkg::SIGN_BITS-1] && (|peak_sign);
    assign sample_neg = sample[gspd_pkg::SAMPLE_BITS-1];
    assign sample_pos = !sample[gspd_pkg::SAMPLE_BITS-1] && (|sample);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            gspd_pkg::PH_LOOK:
            begin
                if (sign_pos && (sample > cfg.swing_threshold))
                    phase_next = gspd_pkg::PH_SWING;
            end
            gspd_pkg::PH_SWING:
            begin
                if (!sign_pos && sample_neg && sign_neg)
                    phase_next = gspd_pkg::PH_STRIKE;
            end
            gspd_pkg::PH_POTENTIAL:
            begin
                if (!sign_neg && sample_pos)
                    phase_next = gspd_pkg::PH_SWING;
                else
                    phase_next = gspd_pkg::PH_STRIKE;
            end
            gspd_pkg::PH_STRIKE:
            begin
                if (!sign_neg)
                    phase_next = gspd_pkg::PH_FLAT;
            end
            gspd_pkg::PH_FLAT:
            begin
                if (sign_neg)
                    phase_next = gspd_pkg::PH_HEELOFF;
            end
            gspd_pkg::PH_HEELOFF:
            begin
                if (sign_pos)
                    phase_next = gspd_pkg::PH_LOOK;
            end
            default:
            begin
                phase_next = gspd_pkg::PH_LOOK;
            end
        endcase
    end

    // trackers, counters and beep
    always_comb
    begin
        swing_max_next   = swing_max_reg;
        heel_valley_next = heel_valley_reg;
        lift_min_next    = lift_min_reg;
        first_under_next = first_under_reg;
        armed_next       = armed_reg;
        step_cnt_next    = step_cnt_reg;
        good_cnt_next    = good_cnt_reg;
        beep_next        = 1'b0;
        unique case (phase_reg)
            gspd_pkg::PH_LOOK:
            begin
                first_under_next = 1'b1;
                armed_next       = 1'b1;
                if (sign_pos && (sample > cfg.swing_threshold))
                    swing_max_next = sample;
            end
            gspd_pkg::PH_SWING:
            begin
                if (sign_pos && (sample > swing_max_reg))
                    swing_max_next = sample;
            end
            gspd_pkg::PH_POTENTIAL:
            begin
                if (!(!sign_neg && sample_pos))
                    heel_valley_next = sample;
            end
            gspd_pkg::PH_STRIKE:
            begin
                if (first_under_reg)
                begin
                    step_cnt_next    = step_cnt_reg + 1'b1;
                    first_under_next = 1'b0;
                end
                if (sign_neg)
                begin
                    if (sample < heel_valley_reg)
                        heel_valley_next = sample;
                    if ((sample < cfg.good_threshold) && armed_reg)
                    begin
                        good_cnt_next = good_cnt_reg + 1'b1;
                        armed_next    = 1'b0;
                        beep_next     = 1'b1;
                    end
                end
                else
                begin
                    heel_valley_next = '0;
                end
            end
            gspd_pkg::PH_FLAT:
            begin
                lift_min_next = lift_min_reg;
            end
            gspd_pkg::PH_HEELOFF:
            begin
                if (sign_pos)
                    lift_min_next = '0;
                else if (sample < lift_min_reg)
                    lift_min_next = sample;
            end
            default:
            begin
                lift_min_next = lift_min_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= gspd_pkg::PH_LOOK;
            swing_max_reg   <= '0;
            heel_valley_reg <= '0;
            lift_min_reg    <= '0;
            first_under_reg <= 1'b0;
            armed_reg       <= 1'b0;
            step_cnt_reg    <= '0;
            good_cnt_reg    <= '0;
        end
        else if (step_en)
        begin
            phase_reg       <= phase_next;
            swing_max_reg   <= swing_max_next;
            heel_valley_reg <= heel_valley_next;
            lift_min_reg    <= lift_min_next;
            first_under_reg <= first_under_next;
            armed_reg       <= armed_next;
            step_cnt_reg    <= step_cnt_next;
            good_cnt_reg    <= good_cnt_next;
        end
    end

    assign result.phase      = phase_next;
    assign result.beep       = beep_next;
    assign result.steps_seen = step_cnt_next;
    assign result.good_steps = good_cnt_next;
    assign result.peak_swing = swing_max_next;
    assign result.valley_min = heel_valley_next;

    `GSPD_ASSERT_IMPL(a_beep_from_armed_strike, step_en && beep_next,
        (phase_reg == gspd_pkg::PH_STRIKE) && armed_reg, "beep outside an armed heel strike")
    `GSPD_ASSERT_IMPL(a_good_cnt_with_beep, step_en && (good_cnt_next != good_cnt_reg),
        beep_next, "good step counted without beep")
    `GSPD_ASSERT_IMPL(a_valley_zero_off_strike, phase_reg != gspd_pkg::PH_STRIKE,
        heel_valley_reg == '0, "valley tracker nonzero outside heel strike")
    `GSPD_ASSERT_NEXT(a_hold_when_idle, !step_en,
        $stable(phase_reg) && $stable(step_cnt_reg) && $stable(good_cnt_reg),
        "state changed without a step")

endmodule

FILE: rtl/core/gait_step_phase_detector_top.sv
// top level of the gait step phase detector: input register, phase machine, result register
//
//   port group  | direction | contents
//   ------------+-----------+---------------------------------------------------
//   in          | sink      | in_valid, in_stall, sample, peak_sign
//   out         | source    | out_valid, out_stall, phase, beep, steps_seen,
//               |           | good_steps, peak_swing, valley_min
//   cfg         | sink      | cfg_we, cfg_index, cfg_data (write only)
//
// one transfer per cycle sustained while out_stall is low; the phase machine steps once per item
// after the input transfer an item is held in the input register, then in the result register;
// out_valid rises when the item reaches the result register
// in_stall rises only when the input register holds an item and the result register is
// full and stalled, so a waiting result does not block the next input transfer
// reset clears the phase machine, trackers, counters, thresholds and valid flags

module gait_step_phase_detector_top (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [gspd_pkg::SAMPLE_BITS-1:0] sample,
    input  logic signed [gspd_pkg::SIGN_BITS-1:0]   peak_sign,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [2:0]                              phase,
    output logic                                    beep,
    output logic [gspd_pkg::COUNT_BITS-1:0]         steps_seen,
    output logic [gspd_pkg::COUNT_BITS-1:0]         good_steps,
    output logic signed [gspd_pkg::SAMPLE_BITS-1:0] peak_swing,
    output logic signed [gspd_pkg::SAMPLE_BITS-1:0] valley_min,
    input  logic                                    cfg_we,
    input  logic [gspd_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [gspd_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

    logic                                    in_valid_reg;
    logic                                    in_valid_next;
    logic signed [gspd_pkg::SAMPLE_BITS-1:0] sample_reg;
    logic [gspd_pkg::SIGN_BITS-1:0]          sign_reg;
    logic                                    out_valid_reg;
    logic                                    out_valid_next;
    gspd_pkg::result_t                       result_reg;
    gspd_pkg::result_t                       result;
    gspd_pkg::cfg_t                          cfg;
    logic                                    advance;
    logic                                    in_take;

    gspd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gspd_phase_fsm u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (advance),
        .sample    (sample_reg),
        .peak_sign (sign_reg),
        .cfg       (cfg),
        .result    (result)
    );

    // input register moves on when the result register is empty or draining
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign in_valid_next  = in_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sample_reg <= sample;
            sign_reg   <= peak_sign;
        end
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign phase      = result_reg.phase;
    assign beep       = result_reg.beep;
    assign steps_seen = result_reg.steps_seen;
    assign good_steps = result_reg.good_steps;
    assign peak_swing = result_reg.peak_swing;
    assign valley_min = result_reg.valley_min;

endmodule
